// ===== src/kat_pkg.sv =====
// Shared types and codes for the keyed activity table.
package kat_pkg;

    localparam int KEY_BITS = 128;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [2:0] ST_EMPTY       = 3'd0;
    localparam logic [2:0] ST_REACTIVATED = 3'd1;
    localparam logic [2:0] ST_ACTIVE      = 3'd2;
    localparam logic [2:0] ST_STALE       = 3'd3;
    localparam logic [2:0] ST_EVICTED     = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] now;
    } kat_cmd_t;

    typedef struct packed {
        logic [2:0]  add_status;
        logic        found;
        logic [3:0]  slot;
        logic        old_key_valid;
        logic [63:0] old_key_high;
        logic [63:0] old_key_low;
    } kat_rsp_t;

    // Flags that travel with the scan token from cell to cell.
    typedef struct packed {
        logic       valid;
        logic       done;
        logic       vic_valid;
        logic       found;
        logic       old_key_valid;
        logic [2:0] status;
    } scan_flags_t;

endpackage

// ===== src/kat_cell.sv =====
// One table entry with its stage of the scan chain.
module kat_cell #(
    parameter int IDX        = 0,
    parameter int IDX_W      = 4,
    parameter int STAMP_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kat_pkg::kat_cmd_t         cmd,
    input  logic [STAMP_BITS-1:0]     stamp_in,
    input  logic                      evict_en,
    input  logic [IDX_W-1:0]          evict_idx,
    input  kat_pkg::scan_flags_t      flags_in,
    input  logic [IDX_W-1:0]          slot_in,
    input  logic [kat_pkg::KEY_BITS-1:0] old_key_in,
    input  logic [IDX_W-1:0]          vic_idx_in,
    input  logic [STAMP_BITS-1:0]     vic_stamp_in,
    input  logic [kat_pkg::KEY_BITS-1:0] vic_key_in,
    output kat_pkg::scan_flags_t      flags_out,
    output logic [IDX_W-1:0]          slot_out,
    output logic [kat_pkg::KEY_BITS-1:0] old_key_out,
    output logic [IDX_W-1:0]          vic_idx_out,
    output logic [STAMP_BITS-1:0]     vic_stamp_out,
    output logic [kat_pkg::KEY_BITS-1:0] vic_key_out
);
    import kat_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                  present_reg, present_next;
    logic                  active_reg, active_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;

    scan_flags_t           flags_reg, flags_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [KEY_BITS-1:0]   old_key_reg, old_key_next;
    logic [IDX_W-1:0]      vic_idx_reg, vic_idx_next;
    logic [STAMP_BITS-1:0] vic_stamp_reg, vic_stamp_next;
    logic [KEY_BITS-1:0]   vic_key_reg, vic_key_next;

    logic [KEY_BITS-1:0]   cmd_key;
    logic                  hit;

    assign cmd_key = {cmd.key_high, cmd.key_low};
    assign hit     = present_reg && (key_reg == cmd_key);

    always_comb
    begin
        flags_next     = flags_in;
        slot_next      = slot_in;
        old_key_next   = old_key_in;
        vic_idx_next   = vic_idx_in;
        vic_stamp_next = vic_stamp_in;
        vic_key_next   = vic_key_in;
        present_next   = present_reg;
        active_next    = active_reg;
        key_next       = key_reg;
        stamp_next     = stamp_reg;

        if (flags_in.valid && !flags_in.done)
        begin
            case (cmd.kind)
                KIND_ADD:
                begin
                    if (hit)
                    begin
                        flags_next.status = active_reg ? ST_ACTIVE : ST_REACTIVATED;
                        flags_next.done   = 1'b1;
                        slot_next         = MY_IDX;
                        active_next       = 1'b1;
                        stamp_next        = stamp_in;
                    end
                    else if (!active_reg)
                    begin
                        // Take over a free entry; report the stale key it held.
                        flags_next.status        = present_reg ? ST_STALE : ST_EMPTY;
                        flags_next.old_key_valid = present_reg;
                        flags_next.done          = 1'b1;
                        if (present_reg)
                        begin
                            old_key_next = key_reg;
                        end
                        slot_next    = MY_IDX;
                        present_next = 1'b1;
                        active_next  = 1'b1;
                        key_next     = cmd_key;
                        stamp_next   = stamp_in;
                    end
                    else if (!flags_in.vic_valid || (stamp_reg < vic_stamp_in))
                    begin
                        flags_next.vic_valid = 1'b1;
                        vic_idx_next         = MY_IDX;
                        vic_stamp_next       = stamp_reg;
                        vic_key_next         = key_reg;
                    end
                end
                KIND_REMOVE, KIND_QUERY:
                begin
                    if (active_reg && hit)
                    begin
                        flags_next.found = 1'b1;
                        flags_next.done  = 1'b1;
                        slot_next        = MY_IDX;
                        if (cmd.kind == KIND_REMOVE)
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    flags_next.done = 1'b1;
                end
            endcase
        end

        if (evict_en && (evict_idx == MY_IDX))
        begin
            present_next = 1'b1;
            active_next  = 1'b1;
            key_next     = cmd_key;
            stamp_next   = stamp_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            active_reg  <= 1'b0;
            stamp_reg   <= '0;
            flags_reg   <= '0;
        end
        else
        begin
            present_reg <= present_next;
            active_reg  <= active_next;
            stamp_reg   <= stamp_next;
            flags_reg   <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        slot_reg      <= slot_next;
        old_key_reg   <= old_key_next;
        vic_idx_reg   <= vic_idx_next;
        vic_stamp_reg <= vic_stamp_next;
        vic_key_reg   <= vic_key_next;
    end

    assign flags_out     = flags_reg;
    assign slot_out      = slot_reg;
    assign old_key_out   = old_key_reg;
    assign vic_idx_out   = vic_idx_reg;
    assign vic_stamp_out = vic_stamp_reg;
    assign vic_key_out   = vic_key_reg;

endmodule

// ===== src/keyed_activity_table_unit.sv =====
// Top level of the keyed activity table: command register, cell chain, result register.
//
// Fully associative table of ENTRIES keyed entries with oldest-stamp replacement.
// Command channel (cmd_valid / cmd_stall / cmd): add or refresh, remove, or query
// a 128-bit key. Result channel (rsp_valid / rsp_stall / rsp): one result per
// command. A transaction moves at a clock edge with valid high and stall low.
// The command is held in a register and broadcast to a chain of ENTRIES cells,
// one entry per cell; a scan token walks the chain one cell per cycle, so the
// first matching or free entry wins and the oldest-stamp victim is tracked on
// the way. An add that finds every entry active passes through an evict state
// that writes the victim. One command is in work at a time, so a new command
// waits until the walk through the chain and the result hand-off are done.
// cmd_stall stays high while a command is in work. The result register lets
// the next command enter while a result waits; a stalled result holds and the
// finished next result waits in its buffer. Reset clears every entry at once
// and empties both sides.
module keyed_activity_table_unit #(
    parameter int ENTRIES    = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  kat_pkg::kat_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output kat_pkg::kat_rsp_t rsp
);
    import kat_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_EVICT = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    logic [1:0]            state_reg, state_next;
    kat_cmd_t              cmd_reg, cmd_next;
    logic                  start_reg, start_next;

    logic [2:0]            res_status_reg, res_status_next;
    logic                  res_found_reg, res_found_next;
    logic [IDX_W-1:0]      res_slot_reg, res_slot_next;
    logic                  res_okv_reg, res_okv_next;
    logic [KEY_BITS-1:0]   res_old_key_reg, res_old_key_next;

    kat_rsp_t              rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    scan_flags_t           flags   [ENTRIES+1];
    logic [IDX_W-1:0]      slot    [ENTRIES+1];
    logic [KEY_BITS-1:0]   old_key [ENTRIES+1];
    logic [IDX_W-1:0]      vic_idx [ENTRIES+1];
    logic [STAMP_BITS-1:0] vic_stamp [ENTRIES+1];
    logic [KEY_BITS-1:0]   vic_key [ENTRIES+1];

    logic [63:0]           now_ext;
    logic [STAMP_BITS-1:0] stamp_in;
    logic                  evict_en;
    logic [15:0]           slot_ext;
    scan_flags_t           head;
    scan_flags_t           tail;

    assign now_ext  = {32'd0, cmd_reg.now};
    assign stamp_in = now_ext[STAMP_BITS-1:0];
    assign evict_en = (state_reg == S_EVICT);

    always_comb
    begin
        head       = '0;
        head.valid = start_reg;
    end
    assign flags[0]     = head;
    assign slot[0]      = '0;
    assign old_key[0]   = '0;
    assign vic_idx[0]   = '0;
    assign vic_stamp[0] = '0;
    assign vic_key[0]   = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        kat_cell #(
            .IDX        (g),
            .IDX_W      (IDX_W),
            .STAMP_BITS (STAMP_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd_reg),
            .stamp_in      (stamp_in),
            .evict_en      (evict_en),
            .evict_idx     (res_slot_reg),
            .flags_in      (flags[g]),
            .slot_in       (slot[g]),
            .old_key_in    (old_key[g]),
            .vic_idx_in    (vic_idx[g]),
            .vic_stamp_in  (vic_stamp[g]),
            .vic_key_in    (vic_key[g]),
            .flags_out     (flags[g+1]),
            .slot_out      (slot[g+1]),
            .old_key_out   (old_key[g+1]),
            .vic_idx_out   (vic_idx[g+1]),
            .vic_stamp_out (vic_stamp[g+1]),
            .vic_key_out   (vic_key[g+1])
        );
    end

    assign tail     = flags[ENTRIES];
    assign slot_ext = 16'(res_slot_reg);

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        start_next       = 1'b0;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_slot_next    = res_slot_reg;
        res_okv_next     = res_okv_reg;
        res_old_key_next = res_old_key_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;

        // Drop the held result once it is taken.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    start_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    if ((cmd_reg.kind == KIND_ADD) && !tail.done)
                    begin
                        // Every entry active: replace the oldest stamp.
                        res_status_next  = ST_EVICTED;
                        res_found_next   = 1'b0;
                        res_slot_next    = vic_idx[ENTRIES];
                        res_okv_next     = 1'b1;
                        res_old_key_next = vic_key[ENTRIES];
                        state_next       = S_EVICT;
                    end
                    else
                    begin
                        res_status_next  = tail.status;
                        res_found_next   = tail.found;
                        res_slot_next    = slot[ENTRIES];
                        res_okv_next     = tail.old_key_valid;
                        res_old_key_next = old_key[ENTRIES];
                        state_next       = S_WAIT;
                    end
                end
            end
            S_EVICT:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.add_status    = res_status_reg;
                    rsp_next.found         = res_found_reg;
                    rsp_next.slot          = slot_ext[3:0];
                    rsp_next.old_key_valid = res_okv_reg;
                    rsp_next.old_key_high  = res_old_key_reg[KEY_BITS-1:64];
                    rsp_next.old_key_low   = res_old_key_reg[63:0];
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_slot_reg    <= res_slot_next;
        res_okv_reg     <= res_okv_next;
        res_old_key_reg <= res_old_key_next;
        rsp_reg         <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/kat_checker.sv =====
// Port-level checks for the keyed activity table, bound to the top level.
module kat_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input kat_pkg::kat_cmd_t cmd,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input kat_pkg::kat_rsp_t rsp
);
    import kat_pkg::*;

    // A stalled command holds until taken.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("stalled command changed");

    // A stalled result holds until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // One command in work at a time.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command channel open right after a transaction");

    // The chain walk comes first, so no result appears right away.
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && !rsp_valid |=> !rsp_valid)
        else $error("result appeared one cycle after the command");

    // Only a replacement reports a displaced key.
    a_old_key_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.old_key_valid |->
            (rsp.add_status == ST_STALE) || (rsp.add_status == ST_EVICTED))
        else $error("displaced key reported without replacement");

endmodule

bind keyed_activity_table_unit kat_checker u_kat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
